// ===== rtl/dnms_pkg.sv =====
package dnms_pkg;

   localparam int MAX_BOXES = 64;
   localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CNT_W = $clog2(MAX_BOXES + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] THRESH_RESET = 16'h8000;

   // cx sits in the low bits, h in the high bits
   typedef struct packed {
      logic [15:0] h;
      logic [15:0] w;
      logic [15:0] cy;
      logic [15:0] cx;
   } geom_type;

   localparam int GEOM_W = $bits(geom_type);
   localparam int SC_W = 24;

   // one queued word: a box to store, a frame close, or both
   typedef struct packed {
      logic is_box;
      logic is_end;
      geom_type geom;
      logic [15:0] score;
      logic [7:0] class_id;
   } word_type;

endpackage

// ===== rtl/dnms_ram.sv =====
module dnms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dnms_front.sv =====
module dnms_front (
   input  logic req_valid,
   output logic req_stall,
   input  logic req_has_box,
   input  logic [15:0] req_center_x,
   input  logic [15:0] req_center_y,
   input  logic [15:0] req_box_width,
   input  logic [15:0] req_box_height,
   input  logic [15:0] req_score,
   input  logic [7:0] req_class_id,
   input  logic req_frame_last,
   input  logic q_full,
   output logic q_push,
   output dnms_pkg::word_type q_word
);

   logic is_box;

   // zero-score boxes are dropped here; empty non-closing words never enter the queue
   assign is_box = req_has_box && (req_score != 16'd0);

   assign req_stall = q_full;
   assign q_push = req_valid && !q_full && (is_box || req_frame_last);

   always_comb begin
      q_word.is_box = is_box;
      q_word.is_end = req_frame_last;
      q_word.geom.cx = req_center_x;
      q_word.geom.cy = req_center_y;
      q_word.geom.w = req_box_width;
      q_word.geom.h = req_box_height;
      q_word.score = req_score;
      q_word.class_id = req_class_id;
   end

endmodule

// ===== rtl/dnms_queue.sv =====
module dnms_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  dnms_pkg::word_type push_word,
   output logic full,
   input  logic pop,
   output dnms_pkg::word_type pop_word,
   output logic empty
);

   dnms_pkg::word_type entries_ff [dnms_pkg::QUEUE_DEPTH];
   logic [dnms_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [dnms_pkg::QPTR_W:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == (dnms_pkg::QPTR_W + 1)'(dnms_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_word = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== rtl/dnms_diou.sv =====
module dnms_diou (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  dnms_pkg::geom_type box_a,
   input  dnms_pkg::geom_type box_b,
   input  logic [15:0] threshold,
   output logic done,
   output logic hit
);

   localparam int A_W = 52;
   localparam int B_W = 48;
   localparam int ACC_W = A_W + B_W;
   localparam int CMP_W = 91;

   typedef enum logic [5:0] {
      D_IDLE = 6'b000001,
      D_GEO  = 6'b000010,
      D_LOAD = 6'b000100,
      D_MUL  = 6'b001000,
      D_SUM  = 6'b010000,
      D_CMP  = 6'b100000
   } dstate_type;

   localparam logic [3:0] K_INTER = 4'd0;
   localparam logic [3:0] K_AREA_A = 4'd1;
   localparam logic [3:0] K_AREA_B = 4'd2;
   localparam logic [3:0] K_DXX = 4'd3;
   localparam logic [3:0] K_DYY = 4'd4;
   localparam logic [3:0] K_EXX = 4'd5;
   localparam logic [3:0] K_EYY = 4'd6;
   localparam logic [3:0] K_LHS = 4'd7;
   localparam logic [3:0] K_DU = 4'd8;
   localparam logic [3:0] K_TU = 4'd9;
   localparam logic [3:0] K_TUD = 4'd10;

   dstate_type state_ff, state_in;
   logic [3:0] k_ff, k_in;
   logic [1:0] dg_ff, dg_in;
   logic done_ff, done_in, hit_ff, hit_in;

   logic [A_W-1:0] a_ff, a_in, op_a;
   logic [B_W-1:0] b_ff, b_in, op_b;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [A_W+15:0] part;

   logic [16:0] iw_ff, iw_in, ih_ff, ih_in, adx_ff, adx_in, ady_ff, ady_in;
   logic [17:0] ex_ff, ex_in, ey_ff, ey_in;
   logic [33:0] inter_ff, inter_in, area_a_ff, area_a_in, area_b_ff, area_b_in;
   logic [33:0] dxx_ff, dxx_in, dyy_ff, dyy_in;
   logic [35:0] exx_ff, exx_in, eyy_ff, eyy_in;
   logic [35:0] uni_ff, uni_in;
   logic [34:0] dist_ff, dist_in;
   logic [36:0] diag_ff, diag_in;
   logic [70:0] lhs_ff, lhs_in, du_ff, du_in;
   logic [51:0] tu_ff, tu_in;
   logic [88:0] tud_ff, tud_in;

   logic signed [18:0] la, ra, ta, ba, lb, rb, tb, bb;
   logic signed [18:0] il, ir, it, ib, iw, ih, ol, orr, ot, ob, ex, ey;
   logic [15:0] dx, dy;
   logic [CMP_W-1:0] lhs, rhs;

   assign done = done_ff;
   assign hit = hit_ff;

   // box edges at doubled scale: 2*center -/+ size
   always_comb begin
      la = $signed({2'b00, box_a.cx, 1'b0}) - $signed({3'b000, box_a.w});
      ra = $signed({2'b00, box_a.cx, 1'b0}) + $signed({3'b000, box_a.w});
      ta = $signed({2'b00, box_a.cy, 1'b0}) - $signed({3'b000, box_a.h});
      ba = $signed({2'b00, box_a.cy, 1'b0}) + $signed({3'b000, box_a.h});
      lb = $signed({2'b00, box_b.cx, 1'b0}) - $signed({3'b000, box_b.w});
      rb = $signed({2'b00, box_b.cx, 1'b0}) + $signed({3'b000, box_b.w});
      tb = $signed({2'b00, box_b.cy, 1'b0}) - $signed({3'b000, box_b.h});
      bb = $signed({2'b00, box_b.cy, 1'b0}) + $signed({3'b000, box_b.h});
      il = (la > lb) ? la : lb;
      ir = (ra < rb) ? ra : rb;
      it = (ta > tb) ? ta : tb;
      ib = (ba < bb) ? ba : bb;
      ol = (la < lb) ? la : lb;
      orr = (ra > rb) ? ra : rb;
      ot = (ta < tb) ? ta : tb;
      ob = (ba > bb) ? ba : bb;
      iw = ir - il;
      ih = ib - it;
      ex = orr - ol;
      ey = ob - ot;
      dx = (box_a.cx >= box_b.cx) ? (box_a.cx - box_b.cx) : (box_b.cx - box_a.cx);
      dy = (box_a.cy >= box_b.cy) ? (box_a.cy - box_b.cy) : (box_b.cy - box_a.cy);
   end

   always_comb begin
      case (k_ff)
         K_INTER: begin
            op_a = A_W'(iw_ff);
            op_b = B_W'(ih_ff);
         end
         K_AREA_A: begin
            op_a = A_W'({box_a.w, 1'b0});
            op_b = B_W'({box_a.h, 1'b0});
         end
         K_AREA_B: begin
            op_a = A_W'({box_b.w, 1'b0});
            op_b = B_W'({box_b.h, 1'b0});
         end
         K_DXX: begin
            op_a = A_W'(adx_ff);
            op_b = B_W'(adx_ff);
         end
         K_DYY: begin
            op_a = A_W'(ady_ff);
            op_b = B_W'(ady_ff);
         end
         K_EXX: begin
            op_a = A_W'(ex_ff);
            op_b = B_W'(ex_ff);
         end
         K_EYY: begin
            op_a = A_W'(ey_ff);
            op_b = B_W'(ey_ff);
         end
         K_LHS: begin
            op_a = A_W'(diag_ff);
            op_b = B_W'(inter_ff);
         end
         K_DU: begin
            op_a = A_W'(uni_ff);
            op_b = B_W'(dist_ff);
         end
         K_TU: begin
            op_a = A_W'(uni_ff);
            op_b = B_W'(threshold);
         end
         K_TUD: begin
            op_a = tu_ff;
            op_b = B_W'(diag_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      dg_in = dg_ff;
      done_in = 1'b0;
      hit_in = hit_ff;
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      iw_in = iw_ff;
      ih_in = ih_ff;
      adx_in = adx_ff;
      ady_in = ady_ff;
      ex_in = ex_ff;
      ey_in = ey_ff;
      inter_in = inter_ff;
      area_a_in = area_a_ff;
      area_b_in = area_b_ff;
      dxx_in = dxx_ff;
      dyy_in = dyy_ff;
      exx_in = exx_ff;
      eyy_in = eyy_ff;
      uni_in = uni_ff;
      dist_in = dist_ff;
      diag_in = diag_ff;
      lhs_in = lhs_ff;
      du_in = du_ff;
      tu_in = tu_ff;
      tud_in = tud_ff;
      part = a_ff * b_ff[B_W-1 -: 16];
      lhs = CMP_W'({lhs_ff, 16'd0});
      rhs = CMP_W'({du_ff, 16'd0}) + CMP_W'(tud_ff);
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               state_in = D_GEO;
            end
         end
         D_GEO: begin
            iw_in = iw[16:0];
            ih_in = ih[16:0];
            adx_in = {dx, 1'b0};
            ady_in = {dy, 1'b0};
            ex_in = ex[17:0];
            ey_in = ey[17:0];
            k_in = K_INTER;
            if (iw[18] || ih[18]) begin
               // disjoint: never suppresses
               hit_in = 1'b0;
               done_in = 1'b1;
               state_in = D_IDLE;
            end else begin
               state_in = D_LOAD;
            end
         end
         D_LOAD: begin
            a_in = op_a;
            b_in = op_b;
            acc_in = '0;
            dg_in = 2'd0;
            state_in = D_MUL;
         end
         D_MUL: begin
            // one 16-bit digit of b per cycle, most significant first
            acc_in = {acc_ff[ACC_W-17:0], 16'd0} + ACC_W'(part);
            b_in = {b_ff[B_W-17:0], 16'd0};
            dg_in = dg_ff + 2'd1;
            if (dg_ff == 2'd2) begin
               case (k_ff)
                  K_INTER: inter_in = acc_in[33:0];
                  K_AREA_A: area_a_in = acc_in[33:0];
                  K_AREA_B: area_b_in = acc_in[33:0];
                  K_DXX: dxx_in = acc_in[33:0];
                  K_DYY: dyy_in = acc_in[33:0];
                  K_EXX: exx_in = acc_in[35:0];
                  K_EYY: eyy_in = acc_in[35:0];
                  K_LHS: lhs_in = acc_in[70:0];
                  K_DU: du_in = acc_in[70:0];
                  K_TU: tu_in = acc_in[51:0];
                  K_TUD: tud_in = acc_in[88:0];
                  default: tud_in = tud_ff;
               endcase
               k_in = k_ff + 4'd1;
               if (k_ff == K_EYY) begin
                  state_in = D_SUM;
               end else if (k_ff == K_TUD) begin
                  state_in = D_CMP;
               end else begin
                  state_in = D_LOAD;
               end
            end
         end
         D_SUM: begin
            uni_in = 36'(area_a_ff) + 36'(area_b_ff) - 36'(inter_ff);
            dist_in = 35'(dxx_ff) + 35'(dyy_ff);
            diag_in = 37'(exx_ff) + 37'(eyy_ff);
            if (uni_in == '0) begin
               hit_in = 1'b0;
               done_in = 1'b1;
               state_in = D_IDLE;
            end else begin
               state_in = D_LOAD;
            end
         end
         D_CMP: begin
            hit_in = (lhs > rhs);
            done_in = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff <= 1'b0;
         hit_ff <= 1'b0;
         k_ff <= '0;
         dg_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
         hit_ff <= hit_in;
         k_ff <= k_in;
         dg_ff <= dg_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
      iw_ff <= iw_in;
      ih_ff <= ih_in;
      adx_ff <= adx_in;
      ady_ff <= ady_in;
      ex_ff <= ex_in;
      ey_ff <= ey_in;
      inter_ff <= inter_in;
      area_a_ff <= area_a_in;
      area_b_ff <= area_b_in;
      dxx_ff <= dxx_in;
      dyy_ff <= dyy_in;
      exx_ff <= exx_in;
      eyy_ff <= eyy_in;
      uni_ff <= uni_in;
      dist_ff <= dist_in;
      diag_ff <= diag_in;
      lhs_ff <= lhs_in;
      du_ff <= du_in;
      tu_ff <= tu_in;
      tud_ff <= tud_in;
   end

endmodule

// ===== rtl/dnms_engine.sv =====
module dnms_engine (
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   input  dnms_pkg::word_type q_word,
   output logic q_pop,
   input  logic [15:0] threshold,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_out_valid,
   output logic [15:0] rsp_out_center_x,
   output logic [15:0] rsp_out_center_y,
   output logic [15:0] rsp_out_width,
   output logic [15:0] rsp_out_height,
   output logic [15:0] rsp_out_score,
   output logic [7:0] rsp_out_class,
   output logic rsp_overflowed,
   output logic rsp_out_last
);

   localparam int MB = dnms_pkg::MAX_BOXES;
   localparam int IW = dnms_pkg::IDX_W;
   localparam int CW = dnms_pkg::CNT_W;

   typedef enum logic [16:0] {
      S_LOAD  = 17'h00001,
      S_RK_I  = 17'h00002,
      S_RK_IW = 17'h00004,
      S_RK_J  = 17'h00008,
      S_RK_JW = 17'h00010,
      S_RK_WR = 17'h00020,
      S_SP_A  = 17'h00040,
      S_SP_AW = 17'h00080,
      S_SP_AG = 17'h00100,
      S_SP_B  = 17'h00200,
      S_SP_BW = 17'h00400,
      S_SP_BG = 17'h00800,
      S_SP_T  = 17'h01000,
      S_EM    = 17'h02000,
      S_EMW   = 17'h04000,
      S_EMG   = 17'h08000,
      S_EMPTY = 17'h10000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, i_ff, i_in, j_ff, j_in, rank_ff, rank_in;
   logic [CW-1:0] supcnt_ff, supcnt_in, emit_ff, emit_in;
   logic ovf_ff, ovf_in;
   logic [MB-1:0] sup_ff, sup_in;
   logic [15:0] si_ff, si_in;
   logic [IW-1:0] idx_ff, idx_in;
   dnms_pkg::geom_type ga_ff, ga_in, gb_ff, gb_in;

   logic geo_we, ord_we, test_start, test_done, test_hit;
   logic [IW-1:0] geo_raddr, sc_raddr, ord_raddr, ord_rd;
   dnms_pkg::geom_type geo_rd;
   logic [dnms_pkg::SC_W-1:0] sc_rd;

   logic out_free, out_load, out_box, out_last;
   logic rsp_valid_ff, rsp_valid_in;
   logic o_valid_ff, o_ovf_ff, o_last_ff;
   dnms_pkg::geom_type o_geom_ff;
   logic [15:0] o_score_ff;
   logic [7:0] o_class_ff;

   dnms_ram #(.WIDTH(dnms_pkg::GEOM_W), .DEPTH(MB)) u_geo_ram (
      .clock   (clock),
      .wr_en   (geo_we),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (q_word.geom),
      .rd_addr (geo_raddr),
      .rd_data (geo_rd)
   );

   dnms_ram #(.WIDTH(dnms_pkg::SC_W), .DEPTH(MB)) u_sc_ram (
      .clock   (clock),
      .wr_en   (geo_we),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data ({q_word.class_id, q_word.score}),
      .rd_addr (sc_raddr),
      .rd_data (sc_rd)
   );

   dnms_ram #(.WIDTH(IW), .DEPTH(MB)) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (rank_ff[IW-1:0]),
      .wr_data (i_ff[IW-1:0]),
      .rd_addr (ord_raddr),
      .rd_data (ord_rd)
   );

   dnms_diou u_diou (
      .clock     (clock),
      .reset     (reset),
      .start     (test_start),
      .box_a     (ga_ff),
      .box_b     (gb_ff),
      .threshold (threshold),
      .done      (test_done),
      .hit       (test_hit)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      i_in = i_ff;
      j_in = j_ff;
      rank_in = rank_ff;
      supcnt_in = supcnt_ff;
      emit_in = emit_ff;
      ovf_in = ovf_ff;
      sup_in = sup_ff;
      si_in = si_ff;
      idx_in = idx_ff;
      ga_in = ga_ff;
      gb_in = gb_ff;
      q_pop = 1'b0;
      geo_we = 1'b0;
      ord_we = 1'b0;
      test_start = 1'b0;
      out_load = 1'b0;
      out_box = 1'b0;
      out_last = 1'b0;
      geo_raddr = idx_ff;
      sc_raddr = idx_ff;
      ord_raddr = i_ff[IW-1:0];
      case (state_ff)
         S_LOAD: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_word.is_box) begin
                  if (count_ff < CW'(MB)) begin
                     geo_we = 1'b1;
                     count_in = count_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (q_word.is_end) begin
                  i_in = '0;
                  state_in = (count_in == '0) ? S_EMPTY : S_RK_I;
               end
            end
         end
         // rank of box i = boxes with higher score, or equal score and earlier arrival
         S_RK_I: begin
            sc_raddr = i_ff[IW-1:0];
            state_in = S_RK_IW;
         end
         S_RK_IW: begin
            si_in = sc_rd[15:0];
            j_in = '0;
            rank_in = '0;
            state_in = S_RK_J;
         end
         S_RK_J: begin
            sc_raddr = j_ff[IW-1:0];
            state_in = S_RK_JW;
         end
         S_RK_JW: begin
            if (sc_rd[15:0] > si_ff || (sc_rd[15:0] == si_ff && j_ff < i_ff)) begin
               rank_in = rank_ff + 1'b1;
            end
            j_in = j_ff + 1'b1;
            state_in = (j_in == count_ff) ? S_RK_WR : S_RK_J;
         end
         S_RK_WR: begin
            ord_we = 1'b1;
            i_in = i_ff + 1'b1;
            if (i_in == count_ff) begin
               i_in = '0;
               state_in = S_SP_A;
            end else begin
               state_in = S_RK_I;
            end
         end
         S_SP_A: begin
            if (i_ff == count_ff) begin
               i_in = '0;
               emit_in = '0;
               state_in = S_EM;
            end else begin
               ord_raddr = i_ff[IW-1:0];
               state_in = S_SP_AW;
            end
         end
         S_SP_AW: begin
            if (sup_ff[ord_rd]) begin
               i_in = i_ff + 1'b1;
               state_in = S_SP_A;
            end else begin
               geo_raddr = ord_rd;
               state_in = S_SP_AG;
            end
         end
         S_SP_AG: begin
            ga_in = geo_rd;
            j_in = i_ff + 1'b1;
            state_in = S_SP_B;
         end
         S_SP_B: begin
            if (j_ff == count_ff) begin
               i_in = i_ff + 1'b1;
               state_in = S_SP_A;
            end else begin
               ord_raddr = j_ff[IW-1:0];
               state_in = S_SP_BW;
            end
         end
         S_SP_BW: begin
            idx_in = ord_rd;
            if (sup_ff[ord_rd]) begin
               j_in = j_ff + 1'b1;
               state_in = S_SP_B;
            end else begin
               geo_raddr = ord_rd;
               state_in = S_SP_BG;
            end
         end
         S_SP_BG: begin
            gb_in = geo_rd;
            test_start = 1'b1;
            state_in = S_SP_T;
         end
         S_SP_T: begin
            if (test_done) begin
               if (test_hit) begin
                  sup_in[idx_ff] = 1'b1;
                  supcnt_in = supcnt_ff + 1'b1;
               end
               j_in = j_ff + 1'b1;
               state_in = S_SP_B;
            end
         end
         S_EM: begin
            if (i_ff == count_ff) begin
               count_in = '0;
               ovf_in = 1'b0;
               sup_in = '0;
               supcnt_in = '0;
               state_in = S_LOAD;
            end else begin
               ord_raddr = i_ff[IW-1:0];
               state_in = S_EMW;
            end
         end
         S_EMW: begin
            idx_in = ord_rd;
            if (sup_ff[ord_rd]) begin
               i_in = i_ff + 1'b1;
               state_in = S_EM;
            end else begin
               geo_raddr = ord_rd;
               sc_raddr = ord_rd;
               state_in = S_EMG;
            end
         end
         S_EMG: begin
            if (out_free) begin
               out_load = 1'b1;
               out_box = 1'b1;
               out_last = ((emit_ff + 1'b1) == (count_ff - supcnt_ff));
               emit_in = emit_ff + 1'b1;
               i_in = i_ff + 1'b1;
               state_in = S_EM;
            end
         end
         S_EMPTY: begin
            if (out_free) begin
               out_load = 1'b1;
               out_last = 1'b1;
               count_in = '0;
               ovf_in = 1'b0;
               sup_in = '0;
               supcnt_in = '0;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         rank_ff <= '0;
         supcnt_ff <= '0;
         emit_ff <= '0;
         ovf_ff <= 1'b0;
         sup_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         i_ff <= i_in;
         j_ff <= j_in;
         rank_ff <= rank_in;
         supcnt_ff <= supcnt_in;
         emit_ff <= emit_in;
         ovf_ff <= ovf_in;
         sup_ff <= sup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff <= si_in;
      idx_ff <= idx_in;
      ga_ff <= ga_in;
      gb_ff <= gb_in;
      if (out_load) begin
         o_valid_ff <= out_box;
         o_geom_ff <= out_box ? geo_rd : '0;
         o_score_ff <= out_box ? sc_rd[15:0] : 16'd0;
         o_class_ff <= out_box ? sc_rd[23:16] : 8'd0;
         o_ovf_ff <= ovf_ff;
         o_last_ff <= out_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_valid = o_valid_ff;
   assign rsp_out_center_x = o_geom_ff.cx;
   assign rsp_out_center_y = o_geom_ff.cy;
   assign rsp_out_width = o_geom_ff.w;
   assign rsp_out_height = o_geom_ff.h;
   assign rsp_out_score = o_score_ff;
   assign rsp_out_class = o_class_ff;
   assign rsp_overflowed = o_ovf_ff;
   assign rsp_out_last = o_last_ff;

endmodule

// ===== rtl/diou_non_max_suppression_core.sv =====
// Input words are taken one per cycle into a 4-word queue while it is not full; each box is stored
// as it is popped. On frame close the boxes are ranked through the score RAM port, then pairs of
// unsuppressed boxes get a DIoU test (shared 52x16 digit multiplier, 11 products of 3 digits each),
// then the kept boxes are emitted. First result follows the ranking and tests.
// Reset (synchronous, active high) empties the queue and frame, threshold returns to 0x8000;
// the box memories are not cleared.
module diou_non_max_suppression_core (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_has_box,
   input  logic [15:0] req_center_x,
   input  logic [15:0] req_center_y,
   input  logic [15:0] req_box_width,
   input  logic [15:0] req_box_height,
   input  logic [15:0] req_score,
   input  logic [7:0] req_class_id,
   input  logic req_frame_last,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_out_valid,
   output logic [15:0] rsp_out_center_x,
   output logic [15:0] rsp_out_center_y,
   output logic [15:0] rsp_out_width,
   output logic [15:0] rsp_out_height,
   output logic [15:0] rsp_out_score,
   output logic [7:0] rsp_out_class,
   output logic rsp_overflowed,
   output logic rsp_out_last
);

   logic [15:0] thresh_ff;
   logic q_full, q_push, q_pop, q_empty;
   dnms_pkg::word_type push_word, pop_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= dnms_pkg::THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   dnms_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_has_box    (req_has_box),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_box_width  (req_box_width),
      .req_box_height (req_box_height),
      .req_score      (req_score),
      .req_class_id   (req_class_id),
      .req_frame_last (req_frame_last),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_word         (push_word)
   );

   dnms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (push_word),
      .full      (q_full),
      .pop       (q_pop),
      .pop_word  (pop_word),
      .empty     (q_empty)
   );

   dnms_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_word           (pop_word),
      .q_pop            (q_pop),
      .threshold        (thresh_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_center_x (rsp_out_center_x),
      .rsp_out_center_y (rsp_out_center_y),
      .rsp_out_width    (rsp_out_width),
      .rsp_out_height   (rsp_out_height),
      .rsp_out_score    (rsp_out_score),
      .rsp_out_class    (rsp_out_class),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_out_last     (rsp_out_last)
   );

endmodule
